@@ hdl/bilinear_feature_sampler_defines.svh @@
// Assertion macros used by the sampler front end.
`ifndef BILINEAR_FEATURE_SAMPLER_DEFINES_SVH
`define BILINEAR_FEATURE_SAMPLER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define BFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define BFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bfs_pkg.sv @@
// Types and constants of the bilinear feature sampler.
`timescale 1ns / 1ps
package bfs_pkg;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERT_OFFSET     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_OFFSET    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVATION_GAIN = 3'd6;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [3:0]         load_channel;
        logic [4:0]         load_row;
        logic [4:0]         load_col;
        logic signed [15:0] feature_value;
        logic signed [23:0] loc_y;
        logic signed [23:0] loc_x;
    } in_t;

    typedef struct packed {
        logic [3:0]         out_channel;
        logic signed [31:0] out_value;
        logic               last;
    } out_t;

    typedef struct packed {
        logic [5:0]         map_height;
        logic [5:0]         map_width;
        logic [4:0]         channel_count;
        logic signed [23:0] vert_offset;
        logic signed [23:0] horiz_offset;
        logic [23:0]        inv_scale;
        logic signed [15:0] activation_gain;
    } cfg_t;

    // Side data of one channel read, travels with the memory read
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [3:0]  channel;
        logic        ypar;
        logic        xpar;
        logic [15:0] fy;
        logic [15:0] fx;
    } iss_t;

endpackage

@@ hdl/bfs_store.sv @@
// Feature store: four banks split by row and column parity.
`timescale 1ns / 1ps
module bfs_store #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32,
    localparam int HB    = (MAX_HEIGHT + 1) / 2,
    localparam int WB    = (MAX_WIDTH + 1) / 2,
    localparam int DEPTH = MAX_CHANNELS * HB * WB,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                en,
    input  logic                load_we,
    input  bfs_pkg::in_t        load_data,
    input  logic [AW-1:0]       rd_addr [4],
    output logic signed [15:0]  rd_data [4]
);
    logic          wr_ok;
    logic [1:0]    wr_bank;
    logic [AW-1:0] wr_addr;

    // Decode the load address into bank and bank row
    always_comb
    begin
        wr_ok = (32'(load_data.load_channel) < 32'(MAX_CHANNELS)) &&
                (32'(load_data.load_row) < 32'(MAX_HEIGHT)) &&
                (32'(load_data.load_col) < 32'(MAX_WIDTH));
        wr_bank = {load_data.load_row[0], load_data.load_col[0]};
        wr_addr = AW'(32'(load_data.load_channel) * HB * WB +
                      32'(load_data.load_row[4:1]) * WB + 32'(load_data.load_col[4:1]));
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic signed [15:0] mem [DEPTH];
        logic signed [15:0] q_reg;

        // Write one cell, and while en is high read one neighbor per cycle
        always_ff @(posedge clk)
        begin
            if (load_we && wr_ok && (wr_bank == 2'(b)))
            begin
                mem[wr_addr] <= load_data.feature_value;
            end
            if (en)
            begin
                q_reg <= mem[rd_addr[b]];
            end
        end
        assign rd_data[b] = q_reg;
    end

endmodule

@@ hdl/bfs_seq.sv @@
// Front end: input transfer, grid coordinate math and channel issue.
`timescale 1ns / 1ps
`include "bilinear_feature_sampler_defines.svh"
module bfs_seq #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32,
    localparam int HB    = (MAX_HEIGHT + 1) / 2,
    localparam int WB    = (MAX_WIDTH + 1) / 2,
    localparam int DEPTH = MAX_CHANNELS * HB * WB,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  bfs_pkg::in_t  in_data,
    input  bfs_pkg::cfg_t cfg,
    input  logic          en,
    output logic          load_we,
    output logic [AW-1:0] rd_addr [4],
    output bfs_pkg::iss_t iss
);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_CLAMP, S_ISSUE} state_t;

    state_t             state_reg, state_next;
    logic signed [23:0] ly_reg, ly_next, lx_reg, lx_next;
    logic signed [49:0] py_reg, py_next, px_reg, px_next;
    logic [YW-1:0]      ylo_reg, ylo_next;
    logic [XW-1:0]      xlo_reg, xlo_next;
    logic [15:0]        fy_reg, fy_next, fx_reg, fx_next;
    logic [CW-1:0]      chan_reg, chan_next;
    bfs_pkg::iss_t      iss_reg, iss_next;

    int                 hc, wc, nch;
    logic [40:0]        top_y, top_x, cy, cx, gy, gx;
    logic signed [24:0] dy, dx;
    logic               chan_last;
    logic               issue_end;
    logic               accept;

    // Clamp the configured sizes into the supported range
    always_comb
    begin
        hc  = (int'(cfg.map_height) < 2) ? 2 :
              ((int'(cfg.map_height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg.map_height));
        wc  = (int'(cfg.map_width) < 2) ? 2 :
              ((int'(cfg.map_width) > MAX_WIDTH) ? MAX_WIDTH : int'(cfg.map_width));
        nch = (int'(cfg.channel_count) < 1) ? 1 :
              ((int'(cfg.channel_count) > MAX_CHANNELS) ? MAX_CHANNELS :
               int'(cfg.channel_count));
        top_y = 41'(((hc - 1) << 16) - 1);
        top_x = 41'(((wc - 1) << 16) - 1);
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign load_we   = accept && (in_data.kind == bfs_pkg::KIND_LOAD);
    assign chan_last = (int'(chan_reg) == nch - 1);
    assign issue_end = (state_reg == S_ISSUE) && en && chan_last;

    // Scale the offset location; clamp into the grid
    always_comb
    begin
        dy = 25'(ly_reg) - 25'(cfg.vert_offset);
        dx = 25'(lx_reg) - 25'(cfg.horiz_offset);
        cy = py_reg[48:8];
        cx = px_reg[48:8];
        gy = py_reg[49] ? 41'd0 : ((cy > top_y) ? top_y : cy);
        gx = px_reg[49] ? 41'd0 : ((cx > top_x) ? top_x : cx);
    end

    // Bank addresses of the four neighbors of the current channel
    for (genvar b = 0; b < 4; b++)
    begin : g_addr
        localparam logic PR = 1'((b >> 1) & 1);
        localparam logic PC = 1'(b & 1);
        always_comb
        begin
            rd_addr[b] = AW'(int'(chan_reg) * HB * WB +
                             ((int'(ylo_reg) + int'(ylo_reg[0] ^ PR)) >> 1) * WB +
                             ((int'(xlo_reg) + int'(xlo_reg[0] ^ PC)) >> 1));
        end
    end

    // Next state and registered values
    always_comb
    begin
        state_next = state_reg;
        ly_next    = ly_reg;
        lx_next    = lx_reg;
        py_next    = py_reg;
        px_next    = px_reg;
        ylo_next   = ylo_reg;
        xlo_next   = xlo_reg;
        fy_next    = fy_reg;
        fx_next    = fx_reg;
        chan_next  = chan_reg;
        iss_next   = iss_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_data.kind == bfs_pkg::KIND_QUERY))
                begin
                    ly_next    = in_data.loc_y;
                    lx_next    = in_data.loc_x;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                py_next    = dy * $signed({1'b0, cfg.inv_scale});
                px_next    = dx * $signed({1'b0, cfg.inv_scale});
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                ylo_next   = gy[16 +: YW];
                xlo_next   = gx[16 +: XW];
                fy_next    = gy[15:0];
                fx_next    = gx[15:0];
                chan_next  = '0;
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                if (en && !chan_last)
                begin
                    chan_next = chan_reg + 1'b1;
                end
                else if (en)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // Side data advances with the memory read
        if (en)
        begin
            iss_next.valid   = (state_reg == S_ISSUE);
            iss_next.last    = chan_last;
            iss_next.channel = 4'(chan_reg);
            iss_next.ypar    = ylo_reg[0];
            iss_next.xpar    = xlo_reg[0];
            iss_next.fy      = fy_reg;
            iss_next.fx      = fx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iss_reg   <= '0;
            chan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
            chan_reg  <= chan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ly_reg  <= ly_next;
        lx_reg  <= lx_next;
        py_reg  <= py_next;
        px_reg  <= px_next;
        ylo_reg <= ylo_next;
        xlo_reg <= xlo_next;
        fy_reg  <= fy_next;
        fx_reg  <= fx_next;
    end

    assign iss = iss_reg;

    `BFS_ASSERT_IMP(a_chan_range, state_reg == S_ISSUE, int'(chan_reg) < nch, "channel overrun")
    `BFS_ASSERT_NXT(a_issue_end, issue_end, state_reg == S_IDLE, "issue did not end on last channel")
    `BFS_ASSERT_IMP(a_row_clamp, state_reg == S_ISSUE, int'(ylo_reg) <= hc - 2, "low row beyond map")

endmodule

@@ hdl/bfs_blend.sv @@
// Blend pipeline: row blends, column blend, gain and output register.
`timescale 1ns / 1ps
module bfs_blend (
    input  logic               clk,
    input  logic               rst_n,
    input  bfs_pkg::iss_t      iss,
    input  logic signed [15:0] rd_data [4],
    input  logic signed [15:0] gain,
    output logic               en,
    output logic               out_valid,
    input  logic               out_stall,
    output bfs_pkg::out_t      out_data
);
    logic signed [15:0] a00, a01, a10, a11;
    logic signed [17:0] wxl, wxh, wyl, wyh;
    logic signed [33:0] m00, m01, m10, m11;
    logic signed [33:0] r0_reg, r0_next, r1_reg, r1_next;
    logic signed [51:0] t0, t1;
    logic signed [51:0] bl_reg, bl_next;
    logic signed [67:0] pw;
    logic signed [63:0] p_reg, p_next;
    logic [15:0]        fy1_reg;
    logic [4:0]         tag1_reg, tag2_reg, tag3_reg;
    logic               v1_reg, v2_reg, v3_reg, vo_reg;
    bfs_pkg::out_t      o_reg, o_next;

    // Advance whenever the output register is free or its transfer completes
    assign en = !vo_reg || !out_stall;

    // Pick neighbors by parity of the low row and column
    always_comb
    begin
        a00 = rd_data[{iss.ypar, iss.xpar}];
        a01 = rd_data[{iss.ypar, ~iss.xpar}];
        a10 = rd_data[{~iss.ypar, iss.xpar}];
        a11 = rd_data[{~iss.ypar, ~iss.xpar}];
        wxh = $signed({2'b00, iss.fx});
        wxl = 18'sd65536 - wxh;
        m00 = wxl * a00;
        m01 = wxh * a01;
        m10 = wxl * a10;
        m11 = wxh * a11;
        r0_next = m00 + m01;
        r1_next = m10 + m11;
    end

    // Blend the two rows
    always_comb
    begin
        wyh = $signed({2'b00, fy1_reg});
        wyl = 18'sd65536 - wyh;
        t0  = wyl * r0_reg;
        t1  = wyh * r1_reg;
        bl_next = t0 + t1;
    end

    // Apply the gain; the product stays within 63 bits
    always_comb
    begin
        pw     = bl_reg * gain;
        p_next = pw[63:0];
        // Arithmetic shift floors; the range never reaches saturation
        o_next.out_value   = p_reg[63:32];
        o_next.out_channel = tag3_reg[4:1];
        o_next.last        = tag3_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= iss.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    // Hold payload on stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg   <= r0_next;
            r1_reg   <= r1_next;
            fy1_reg  <= iss.fy;
            tag1_reg <= {iss.channel, iss.last};
            bl_reg   <= bl_next;
            tag2_reg <= tag1_reg;
            p_reg    <= p_next;
            tag3_reg <= tag2_reg;
            o_reg    <= o_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_data  = o_reg;

endmodule

@@ hdl/bilinear_feature_sampler.sv @@
// Bilinear feature sampler: top level with configuration registers.
`timescale 1ns / 1ps
// Use:
//   Input channel in_valid/in_stall/in_data: kind 0 items load one feature
//   cell each, kind 1 items query a location.
//   Output channel out_valid/out_stall/out_data: one transfer per channel in
//   use, channel 0 first, last set on the final one.
//   Configuration: cfg_we writes cfg_data to register cfg_index; write only
//   while the block is idle.
// Timing:
//   A query runs through the front end as the offset times inverse scale
//   multiply, the clamp, then one channel read per cycle from four parity
//   banks while the output does not stall. Results pass the read, row blend,
//   column blend, gain and output registers, one per cycle while not stalled.
// Reset:
//   Control and config registers return to their defaults; the feature store
//   keeps its contents and must be loaded before cells are queried.
// Stall:
//   A stalled output freezes the whole blend pipeline and the channel issue;
//   nothing is lost or repeated.
module bilinear_feature_sampler #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  bfs_pkg::in_t                     in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output bfs_pkg::out_t                    out_data,
    input  logic                             cfg_we,
    input  logic [bfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    localparam int HB    = (MAX_HEIGHT + 1) / 2;
    localparam int WB    = (MAX_WIDTH + 1) / 2;
    localparam int DEPTH = MAX_CHANNELS * HB * WB;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bfs_pkg::cfg_t      cfg_reg;
    logic               en;
    logic               load_we;
    logic [AW-1:0]      rd_addr [4];
    logic signed [15:0] rd_data [4];
    bfs_pkg::iss_t      iss;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_height      <= 6'd32;
            cfg_reg.map_width       <= 6'd32;
            cfg_reg.channel_count   <= 5'd16;
            cfg_reg.vert_offset     <= '0;
            cfg_reg.horiz_offset    <= '0;
            cfg_reg.inv_scale       <= 24'd65536;
            cfg_reg.activation_gain <= 16'sd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bfs_pkg::REG_MAP_HEIGHT:      cfg_reg.map_height      <= cfg_data[5:0];
                bfs_pkg::REG_MAP_WIDTH:       cfg_reg.map_width       <= cfg_data[5:0];
                bfs_pkg::REG_CHANNEL_COUNT:   cfg_reg.channel_count   <= cfg_data[4:0];
                bfs_pkg::REG_VERT_OFFSET:     cfg_reg.vert_offset     <= cfg_data;
                bfs_pkg::REG_HORIZ_OFFSET:    cfg_reg.horiz_offset    <= cfg_data;
                bfs_pkg::REG_INV_SCALE:       cfg_reg.inv_scale       <= cfg_data;
                bfs_pkg::REG_ACTIVATION_GAIN: cfg_reg.activation_gain <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    bfs_seq #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .en       (en),
        .load_we  (load_we),
        .rd_addr  (rd_addr),
        .iss      (iss)
    );

    bfs_store #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH)
    ) u_store (
        .clk       (clk),
        .en        (en),
        .load_we   (load_we),
        .load_data (in_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    bfs_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .iss       (iss),
        .rd_data   (rd_data),
        .gain      (cfg_reg.activation_gain),
        .en        (en),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ tb/bilinear_feature_sampler_tb.sv @@
// Self-checking testbench of the bilinear feature sampler.
`timescale 1ns / 1ps
module bilinear_feature_sampler_tb;

    localparam int NCH = 16;
    localparam int NROW = 32;
    localparam int NCOL = 32;
    localparam int CELLS = NCH * NROW * NCOL;
    localparam logic [bfs_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD = 300;

    typedef struct {
        bfs_pkg::in_t       item;
        bit                 typed;
        logic signed [31:0] value;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    bfs_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    bfs_pkg::out_t out_data;
    logic cfg_we = 1'b0;
    logic [bfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the map and the registers
    logic [15:0] map_cells [0:CELLS-1];
    bit loaded [0:CELLS-1];
    logic [5:0] rows_set = 6'd32;
    logic [5:0] cols_set = 6'd32;
    logic [4:0] chans_set = 5'd16;
    logic signed [23:0] off_y = '0;
    logic signed [23:0] off_x = '0;
    logic [23:0] scale_inv = 24'd65536;
    logic signed [15:0] gain = 16'sd256;

    bfs_pkg::out_t pending_samples [$];
    int errors = 0;
    int items_sent = 0;
    int queries_sent = 0;
    int samples_seen = 0;
    int hold_left = 0;
    bit long_hold_req = 0;
    bit no_idle = 0;
    int quiet_cycles = 0;

    bilinear_feature_sampler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int cell_addr(int ch, int r, int c);
        return (ch * NROW + r) * NCOL + c;
    endfunction

    // Map a Q16.8 location onto the clamped Q.16 grid
    function automatic longint grid_pos(logic signed [23:0] loc, logic signed [23:0] off,
                                        int size);
        longint prod;
        longint top;
        prod = (longint'(loc) - longint'(off)) * longint'(scale_inv);
        if (prod < 0)
            return 0;
        top = (longint'(size - 1) << 16) - 1;
        prod = prod >>> 8;
        return prod > top ? top : prod;
    endfunction

    function automatic longint cell_val(int ch, int r, int c);
        return longint'($signed(map_cells[cell_addr(ch, r, c)]));
    endfunction

    // Expected samples of one query, channel 0 first
    function automatic void sample_query(bfs_pkg::in_t it);
        longint ly, lx, fy, fx, r0, r1, blend, prod, q;
        int y0, x0, nch;
        bfs_pkg::out_t o;
        nch = clampi(chans_set, 1, NCH);
        ly = grid_pos(it.loc_y, off_y, clampi(rows_set, 2, NROW));
        lx = grid_pos(it.loc_x, off_x, clampi(cols_set, 2, NCOL));
        y0 = int'(ly >> 16);
        x0 = int'(lx >> 16);
        fy = ly & 64'hFFFF;
        fx = lx & 64'hFFFF;
        for (int ch = 0; ch < nch; ch++)
        begin
            r0 = (65536 - fx) * cell_val(ch, y0, x0) + fx * cell_val(ch, y0, x0 + 1);
            r1 = (65536 - fx) * cell_val(ch, y0 + 1, x0) + fx * cell_val(ch, y0 + 1, x0 + 1);
            blend = (65536 - fy) * r0 + fy * r1;
            prod = blend * longint'(gain);
            q = prod >>> 32;
            if (q > 64'sd2147483647)
                q = 64'sd2147483647;
            if (q < -64'sd2147483648)
                q = -64'sd2147483648;
            o.out_channel = 4'(ch);
            o.out_value = 32'(q);
            o.last = (ch == nch - 1);
            pending_samples.insert(pending_samples.size(), o);
        end
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic offer(bfs_pkg::in_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (it.kind == bfs_pkg::KIND_LOAD)
        begin
            map_cells[cell_addr(it.load_channel, it.load_row, it.load_col)] = it.feature_value;
            loaded[cell_addr(it.load_channel, it.load_row, it.load_col)] = 1;
        end
        else
        begin
            queries_sent++;
            sample_query(it);
        end
        @(negedge clk);
    endtask

    function automatic bfs_pkg::in_t load_item(int ch, int r, int c, logic [15:0] v);
        bfs_pkg::in_t it;
        it = bfs_pkg::in_t'({$urandom, $urandom, $urandom});
        it.kind = bfs_pkg::KIND_LOAD;
        it.load_channel = 4'(ch);
        it.load_row = 5'(r);
        it.load_col = 5'(c);
        it.feature_value = v;
        return it;
    endfunction

    // Load every cell the query reads that has no value yet, then query
    task automatic send_query(bfs_pkg::in_t it, bit typed, logic signed [31:0] value);
        int y0, x0, nch, a;
        nch = clampi(chans_set, 1, NCH);
        y0 = int'(grid_pos(it.loc_y, off_y, clampi(rows_set, 2, NROW)) >> 16);
        x0 = int'(grid_pos(it.loc_x, off_x, clampi(cols_set, 2, NCOL)) >> 16);
        for (int ch = 0; ch < nch; ch++)
            for (int dy = 0; dy < 2; dy++)
                for (int dx = 0; dx < 2; dx++)
                begin
                    a = cell_addr(ch, y0 + dy, x0 + dx);
                    if (!loaded[a])
                        offer(load_item(ch, y0 + dy, x0 + dx, 16'($urandom)));
                end
        it.kind = bfs_pkg::KIND_QUERY;
        offer(it);
        if (typed)
            pending_samples[pending_samples.size() - nch].out_value = value;
    endtask

    // Drive one register write and update the shadow copy
    task automatic write_reg(logic [bfs_pkg::CFG_IDX_W-1:0] idx,
                             logic [bfs_pkg::CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            bfs_pkg::REG_MAP_HEIGHT:      rows_set = v[5:0];
            bfs_pkg::REG_MAP_WIDTH:       cols_set = v[5:0];
            bfs_pkg::REG_CHANNEL_COUNT:   chans_set = v[4:0];
            bfs_pkg::REG_VERT_OFFSET:     off_y = v;
            bfs_pkg::REG_HORIZ_OFFSET:    off_x = v;
            bfs_pkg::REG_INV_SCALE:       scale_inv = v;
            bfs_pkg::REG_ACTIVATION_GAIN: gain = v[15:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic program_all(int h, int w, int nch, logic [23:0] oy, logic [23:0] ox,
                               logic [23:0] sc, logic [15:0] g);
        write_reg(bfs_pkg::REG_MAP_HEIGHT, 24'(h));
        write_reg(bfs_pkg::REG_MAP_WIDTH, 24'(w));
        write_reg(bfs_pkg::REG_CHANNEL_COUNT, 24'(nch));
        write_reg(bfs_pkg::REG_VERT_OFFSET, oy);
        write_reg(bfs_pkg::REG_HORIZ_OFFSET, ox);
        write_reg(bfs_pkg::REG_INV_SCALE, sc);
        write_reg(bfs_pkg::REG_ACTIVATION_GAIN, {{8{g[15]}}, g});
        write_reg(REG_SPARE, 24'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Wait for every expected sample, then let the pipeline drain
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    function automatic row_t ld(int ch, int r, int c, logic [15:0] v);
        row_t rw;
        rw.item = load_item(ch, r, c, v);
        rw.typed = 0;
        rw.value = '0;
        return rw;
    endfunction

    function automatic row_t qry(logic [23:0] y, logic [23:0] x, bit typed,
                                 logic signed [31:0] v);
        row_t rw;
        rw.item = bfs_pkg::in_t'({$urandom, $urandom, $urandom});
        rw.item.kind = bfs_pkg::KIND_QUERY;
        rw.item.loc_y = y;
        rw.item.loc_x = x;
        rw.typed = typed;
        rw.value = v;
        return rw;
    endfunction

    // Release the output stall as the hold count runs out
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= 1'b0;
    end

    // Check each output transfer against the oldest expectation
    always @(posedge clk)
    begin
        bfs_pkg::out_t exp_s;
        if (rst_n && out_valid && !out_stall)
        begin
            samples_seen++;
            if (pending_samples.size() == 0)
            begin
                $error("unexpected sample: channel %0d value %0d", out_data.out_channel,
                       out_data.out_value);
                errors++;
            end
            else
            begin
                exp_s = pending_samples.pop_front();
                if (out_data.out_channel !== exp_s.out_channel)
                begin
                    $error("out_channel: expected %0d, got %0d", exp_s.out_channel,
                           out_data.out_channel);
                    errors++;
                end
                if (out_data.out_value !== exp_s.out_value)
                begin
                    $error("out_value: expected %0d, got %0d", exp_s.out_value,
                           out_data.out_value);
                    errors++;
                end
                if (out_data.last !== exp_s.last)
                begin
                    $error("last: expected %0d, got %0d", exp_s.last, out_data.last);
                    errors++;
                end
            end
            if (long_hold_req)
            begin
                hold_left <= LONG_HOLD;
                long_hold_req = 0;
            end
            else
                hold_left <= no_idle ? 0 : $urandom_range(0, 9);
        end
    end

    // Abort when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("bilinear_feature_sampler_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        row_t plan [$];
        bfs_pkg::in_t it;
        int h, w, nch, budget, start;
        logic [23:0] oy, ox, sc;
        logic [15:0] g;

        for (int i = 0; i < CELLS; i++)
        begin
            map_cells[i] = '0;
            loaded[i] = 0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: one channel on a 2x2 map, flat extremes first
        program_all(2, 2, 1, 24'd0, 24'd0, 24'd65536, 16'sd256);
        plan = '{
            ld(0, 0, 0, 16'sd32767), ld(0, 0, 1, 16'sd32767),
            ld(0, 1, 0, 16'sd32767), ld(0, 1, 1, 16'sd32767),
            qry(24'd0, 24'd0, 1, 32'sh007FFF00),
            qry(24'h800000, 24'h800000, 1, 32'sh007FFF00),
            qry(24'h7FFFFF, 24'h7FFFFF, 1, 32'sh007FFF00),
            ld(0, 0, 0, 16'h8000), ld(0, 0, 1, 16'h8000),
            ld(0, 1, 0, 16'h8000), ld(0, 1, 1, 16'h8000),
            qry(24'd0, 24'd0, 1, 32'shFF800000),
            qry(24'h7FFFFF, 24'h800000, 1, 32'shFF800000),
            ld(0, 0, 0, 16'sd0), ld(0, 0, 1, 16'sd1), ld(0, 1, 0, 16'h7FFF),
            qry(24'd128, 24'd128, 0, '0),
            qry(24'd64, 24'd192, 0, '0),
            qry(24'd255, 24'd1, 0, '0),
            ld(15, 31, 31, 16'h5A5A), ld(10, 21, 10, 16'hA5A5),
            qry(24'h0000FF, 24'h7FFFFF, 0, '0)
        };
        foreach (plan[i])
        begin
            if (plan[i].item.kind == bfs_pkg::KIND_QUERY)
                send_query(plan[i].item, plan[i].typed, plan[i].value);
            else
                offer(plan[i].item);
        end
        drain();

        // Random part: one register setting per phase, extremes in the first two
        for (int p = 0; p < 9; p++)
        begin
            case (p)
                0:
                begin
                    h = 0; w = 63; nch = 0; oy = 24'h800000; ox = 24'h7FFFFF;
                    sc = 24'd0; g = 16'h7FFF;
                end
                1:
                begin
                    h = 63; w = 0; nch = 31; oy = 24'h7FFFFF; ox = 24'h800000;
                    sc = 24'hFFFFFF; g = 16'h8000;
                end
                default:
                begin
                    h = $urandom_range(2, 5); w = $urandom_range(2, 5);
                    nch = $urandom_range(1, 4);
                    oy = 24'($signed(12'($urandom)));
                    ox = 24'($signed(12'($urandom)));
                    sc = $urandom_range(0, 3) == 0 ? 24'($urandom)
                                                   : 24'($urandom_range(16384, 262144));
                    g = 16'($urandom);
                end
            endcase
            program_all(h, w, nch, oy, ox, sc, g);
            no_idle = (p == 4);
            if (p == 2)
                long_hold_req = 1;
            budget = (p == 1) ? 50 : 35;
            start = items_sent;
            while (items_sent - start < budget)
            begin
                it = bfs_pkg::in_t'({$urandom, $urandom, $urandom});
                case ($urandom_range(0, 5))
                    0: offer(load_item($urandom_range(0, 15), $urandom_range(0, 31),
                                       $urandom_range(0, 31), 16'($urandom)));
                    1, 2: send_query(it, 0, '0);
                    default:
                    begin
                        // Land near the grid so interior cells get blended
                        it.loc_y = off_y + 24'($signed($urandom_range(0, h * 256)) - 64);
                        it.loc_x = off_x + 24'($signed($urandom_range(0, w * 256)) - 64);
                        send_query(it, 0, '0);
                    end
                endcase
                if (p == 3 && items_sent - start == budget / 2)
                begin
                    in_valid <= 1'b0;
                    while (pending_samples.size() != 0)
                        @(negedge clk);
                end
            end
            drain();
        end
        no_idle = 0;

        $display("Sent %0d items (%0d queries) over 10 register settings; checked %0d samples.",
                 items_sent, queries_sent, samples_seen);
        if (errors == 0)
            $display("bilinear_feature_sampler_tb: PASS");
        else
            $display("bilinear_feature_sampler_tb: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/bfs_pkg.sv
hdl/bfs_store.sv
hdl/bfs_seq.sv
hdl/bfs_blend.sv
hdl/bilinear_feature_sampler.sv
tb/bilinear_feature_sampler_tb.sv
